[src/oversample_box_combiner_top_assert.svh]
// assertion helpers, clocked on aclk with aresetn held low as disable
`ifndef OVERSAMPLE_BOX_COMBINER_TOP_ASSERT_SVH
`define OVERSAMPLE_BOX_COMBINER_TOP_ASSERT_SVH

// same-cycle implication
`define OBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

[src/obc_pkg.sv]
`timescale 1ns / 1ps

package obc_pkg;

    localparam int MAX_BOX_DEF     = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SAMPLE_W        = 16;
    localparam int PIXEL_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;
    localparam int BOX_FACTOR_W    = 5;

    typedef enum logic [1:0] {
        MODE_AVG = 2'd0,
        MODE_SUM = 2'd1,
        MODE_MAX = 2'd2,
        MODE_MED = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_BOX    = 2'd1,
        CFG_SIGNED = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_DIV_INIT,
        ST_DIV,
        ST_MED_RD,
        ST_MED_LD,
        ST_MED_SCAN,
        ST_MED_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  acc_en;
        logic  first;
        logic  is_signed;
        mode_t mode;
        logic  load_cand;
        logic  cmp_en;
        logic  div_init;
        logic  div_step;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic med_found;
    } sts_t;

endpackage

[src/obc_datapath.sv]
`timescale 1ns / 1ps

module obc_datapath #(
    parameter int MAX_BOX     = obc_pkg::MAX_BOX_DEF,
    parameter int SAMPLE_BITS = obc_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W = (MAX_BOX > 1) ? $clog2(MAX_BOX) : 1,
    localparam int CNT_W = $clog2(MAX_BOX + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  obc_pkg::cmd_t                cmd,
    output obc_pkg::sts_t                sts,
    input  logic [IDX_W-1:0]             fill_idx,
    input  logic [IDX_W-1:0]             rd_addr,
    input  logic [CNT_W-1:0]             box_n,
    input  logic [obc_pkg::SAMPLE_W-1:0] s_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [obc_pkg::PIXEL_W-1:0]  m_pixel,
    output logic                         m_saturated
);

    localparam int SB    = SAMPLE_BITS;
    localparam int DEC_W = SB + 1;
    localparam int ACC_W = SB + 2 + CNT_W;
    localparam int PW    = obc_pkg::PIXEL_W;

    localparam logic signed [ACC_W-1:0] UMAX = {{(ACC_W-SB){1'b0}}, {SB{1'b1}}};
    localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-SB+1){1'b1}}, {(SB-1){1'b0}}};

    function automatic logic signed [DEC_W-1:0] decode(input logic [SB-1:0] r, input logic sg);
        decode = {sg & r[SB-1], r};
    endfunction

    logic [SB+obc_pkg::SAMPLE_W-1:0] sample_ext;
    logic [SB-1:0]                   raw;
    logic signed [DEC_W-1:0]         s_dec;
    logic signed [ACC_W-1:0]         sum;
    logic signed [ACC_W-1:0]         hi;
    logic signed [ACC_W-1:0]         lo;
    logic signed [ACC_W-1:0]         acc_next;
    logic                            clip_now;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DEC_W-1:0] max_reg;
    logic                    clip_reg;
    logic [SB-1:0]           box_mem [MAX_BOX];
    logic [SB-1:0]           rd_data_reg;

    logic signed [DEC_W-1:0] cand_reg;
    logic [CNT_W-1:0]        less_reg;
    logic [CNT_W-1:0]        eq_reg;
    logic signed [DEC_W-1:0] rd_dec;
    logic [CNT_W:0]          le_sum;
    logic [CNT_W-1:0]        half_n;

    logic [ACC_W-1:0]        q_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic                    neg_reg;
    logic [CNT_W:0]          trial;
    logic                    trial_ge;
    logic [CNT_W:0]          trial_sub;
    logic [ACC_W-1:0]        quot;

    logic [SB-1:0]           pix_val;
    logic [SB+PW-1:0]        pix_ext;

    logic [PW-1:0]           pixel_reg;
    logic                    sat_reg;
    logic                    valid_reg;

    assign sample_ext = {{SB{1'b0}}, s_sample};
    assign raw        = sample_ext[SB-1:0];
    assign s_dec      = decode(raw, cmd.is_signed);
    assign sum        = acc_reg + {{(ACC_W-DEC_W){s_dec[DEC_W-1]}}, s_dec};
    assign hi         = cmd.is_signed ? SMAX : UMAX;
    assign lo         = cmd.is_signed ? SMIN : '0;

    always_comb begin
        acc_next = sum;
        clip_now = 1'b0;
        if (cmd.first) begin
            acc_next = {{(ACC_W-DEC_W){s_dec[DEC_W-1]}}, s_dec};
        end else if (cmd.mode == obc_pkg::MODE_SUM) begin
            if (sum > hi) begin
                acc_next = hi;
                clip_now = 1'b1;
            end else if (sum < lo) begin
                acc_next = lo;
                clip_now = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_en) begin
            box_mem[fill_idx] <= raw;
            acc_reg           <= acc_next;
            clip_reg          <= cmd.first ? 1'b0 : (clip_reg | clip_now);
            if (cmd.first || (s_dec > max_reg)) begin
                max_reg <= s_dec;
            end
        end
        rd_data_reg <= box_mem[rd_addr];
    end

    // median by rank counting
    assign rd_dec = decode(rd_data_reg, cmd.is_signed);
    assign le_sum = {1'b0, less_reg} + {1'b0, eq_reg};
    assign half_n = box_n >> 1;
    assign sts.med_found = (less_reg <= half_n) && ({1'b0, half_n} < le_sum);

    always_ff @(posedge aclk) begin
        if (cmd.load_cand) begin
            cand_reg <= rd_dec;
            less_reg <= '0;
            eq_reg   <= '0;
        end else if (cmd.cmp_en) begin
            if (rd_dec < cand_reg) begin
                less_reg <= less_reg + CNT_W'(1);
            end
            if (rd_dec == cand_reg) begin
                eq_reg <= eq_reg + CNT_W'(1);
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    assign trial     = {rem_reg, q_reg[ACC_W-1]};
    assign trial_ge  = trial >= {1'b0, box_n};
    assign trial_sub = trial - {1'b0, box_n};
    assign quot      = neg_reg ? (~q_reg + ACC_W'(1)) : q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            neg_reg <= acc_reg[ACC_W-1];
            q_reg   <= acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            q_reg   <= {q_reg[ACC_W-2:0], trial_ge};
        end
    end

    always_comb begin
        unique case (cmd.mode)
            obc_pkg::MODE_AVG: pix_val = quot[SB-1:0];
            obc_pkg::MODE_SUM: pix_val = acc_reg[SB-1:0];
            obc_pkg::MODE_MAX: pix_val = max_reg[SB-1:0];
            obc_pkg::MODE_MED: pix_val = cand_reg[SB-1:0];
            default:           pix_val = acc_reg[SB-1:0];
        endcase
    end

    assign pix_ext = {{PW{1'b0}}, pix_val};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            pixel_reg <= pix_ext[PW-1:0];
            sat_reg   <= (cmd.mode == obc_pkg::MODE_SUM) && clip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !valid_reg || m_ready;
    assign m_valid      = valid_reg;
    assign m_pixel      = pixel_reg;
    assign m_saturated  = sat_reg;

endmodule

[src/obc_ctrl.sv]
`timescale 1ns / 1ps

`include "oversample_box_combiner_top_assert.svh"

module obc_ctrl #(
    parameter int MAX_BOX     = obc_pkg::MAX_BOX_DEF,
    parameter int SAMPLE_BITS = obc_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W = (MAX_BOX > 1) ? $clog2(MAX_BOX) : 1,
    localparam int CNT_W = $clog2(MAX_BOX + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [obc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [obc_pkg::CFG_DATA_W-1:0] cfg_data,
    output obc_pkg::cmd_t                  cmd,
    input  obc_pkg::sts_t                  sts,
    output logic [IDX_W-1:0]               fill_idx,
    output logic [IDX_W-1:0]               rd_addr,
    output logic [CNT_W-1:0]               box_n
);

    localparam int ACC_W = SAMPLE_BITS + 2 + CNT_W;
    localparam int DC_W  = $clog2(ACC_W);

    obc_pkg::state_t                  state_reg, state_next;
    obc_pkg::mode_t                   mode_reg;
    logic [obc_pkg::BOX_FACTOR_W-1:0] box_reg;
    logic                             signed_reg;
    logic [CNT_W-1:0]                 fill_reg;
    logic [CNT_W-1:0]                 i_reg;
    logic [CNT_W-1:0]                 j_reg;
    logic [DC_W-1:0]                  div_cnt_reg;
    logic                             accept;
    logic                             box_end;
    logic                             cfg_hit;

    always_comb begin
        if (box_reg == '0) begin
            box_n = CNT_W'(1);
        end else if (int'(box_reg) > MAX_BOX) begin
            box_n = CNT_W'(MAX_BOX);
        end else begin
            box_n = CNT_W'(box_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign box_end   = (fill_reg + CNT_W'(1)) == box_n;
    assign cfg_hit   = cfg_valid && (cfg_index <= obc_pkg::CFG_SIGNED);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            obc_pkg::ST_FILL: begin
                if (accept && box_end) begin
                    unique case (mode_reg)
                        obc_pkg::MODE_AVG: state_next = obc_pkg::ST_DIV_INIT;
                        obc_pkg::MODE_MED: state_next = obc_pkg::ST_MED_RD;
                        default:           state_next = obc_pkg::ST_DONE;
                    endcase
                end
            end
            obc_pkg::ST_DIV_INIT: state_next = obc_pkg::ST_DIV;
            obc_pkg::ST_DIV: begin
                if (div_cnt_reg == DC_W'(ACC_W - 1)) begin
                    state_next = obc_pkg::ST_DONE;
                end
            end
            obc_pkg::ST_MED_RD: state_next = obc_pkg::ST_MED_LD;
            obc_pkg::ST_MED_LD: state_next = obc_pkg::ST_MED_SCAN;
            obc_pkg::ST_MED_SCAN: begin
                if (j_reg == box_n) begin
                    state_next = obc_pkg::ST_MED_CHK;
                end
            end
            obc_pkg::ST_MED_CHK: begin
                state_next = sts.med_found ? obc_pkg::ST_DONE : obc_pkg::ST_MED_RD;
            end
            obc_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    state_next = obc_pkg::ST_FILL;
                end
            end
            default: state_next = obc_pkg::ST_FILL;
        endcase
    end

    always_comb begin
        s_ready       = state_reg == obc_pkg::ST_FILL;
        cmd.acc_en    = accept;
        cmd.first     = fill_reg == '0;
        cmd.is_signed = signed_reg;
        cmd.mode      = mode_reg;
        cmd.load_cand = state_reg == obc_pkg::ST_MED_LD;
        cmd.cmp_en    = state_reg == obc_pkg::ST_MED_SCAN;
        cmd.div_init  = state_reg == obc_pkg::ST_DIV_INIT;
        cmd.div_step  = state_reg == obc_pkg::ST_DIV;
        cmd.out_load  = (state_reg == obc_pkg::ST_DONE) && sts.out_free;
        fill_idx      = fill_reg[IDX_W-1:0];
        unique case (state_reg)
            obc_pkg::ST_MED_RD:   rd_addr = i_reg[IDX_W-1:0];
            obc_pkg::ST_MED_SCAN: rd_addr = j_reg[IDX_W-1:0];
            default:              rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= obc_pkg::ST_FILL;
            mode_reg   <= obc_pkg::MODE_AVG;
            box_reg    <= obc_pkg::BOX_FACTOR_W'(1);
            signed_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                fill_reg <= box_end ? '0 : fill_reg + CNT_W'(1);
            end else if (cfg_hit) begin
                fill_reg <= '0;
            end
            if (cfg_valid) begin
                case (obc_pkg::cfg_idx_t'(cfg_index))
                    obc_pkg::CFG_MODE:   mode_reg   <= obc_pkg::mode_t'(cfg_data[1:0]);
                    obc_pkg::CFG_BOX:    box_reg    <= cfg_data;
                    obc_pkg::CFG_SIGNED: signed_reg <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg       <= '0;
            j_reg       <= '0;
            div_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                obc_pkg::ST_FILL:     i_reg <= '0;
                obc_pkg::ST_MED_CHK:  i_reg <= i_reg + CNT_W'(1);
                default:              ;
            endcase
            if (state_reg == obc_pkg::ST_MED_LD) begin
                j_reg <= CNT_W'(1);
            end else if (state_reg == obc_pkg::ST_MED_SCAN && j_reg != box_n) begin
                j_reg <= j_reg + CNT_W'(1);
            end
            if (state_reg == obc_pkg::ST_DIV) begin
                div_cnt_reg <= div_cnt_reg + DC_W'(1);
            end else begin
                div_cnt_reg <= '0;
            end
        end
    end

    `OBC_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free, "result loaded over waiting word")
    `OBC_ASSERT_IMP(a_fill_bound, state_reg == obc_pkg::ST_FILL, fill_reg < box_n, "fill past box")
    `OBC_ASSERT_NXT(a_box_end, accept && box_end, state_reg != obc_pkg::ST_FILL, "box end missed")
    `OBC_ASSERT_IMP(a_med_rank, state_reg == obc_pkg::ST_MED_RD, i_reg < box_n, "median search ran out")

endmodule

[src/oversample_box_combiner_top.sv]
`timescale 1ns / 1ps

// Combines each run of box_factor samples (1..MAX_BOX) into one pixel by
// average, saturating sum, maximum or median. Samples within a box are taken
// one per cycle; the box-closing word then blocks input while the pixel is
// formed: sum and maximum need no further step, average runs a bit-serial
// divider, and median ranks candidates through the box buffer's single read
// port. A finished pixel waits in the output register while the next box
// fills. A configuration write discards the partial box.
module oversample_box_combiner_top #(
    parameter int MAX_BOX     = obc_pkg::MAX_BOX_DEF,
    parameter int SAMPLE_BITS = obc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [obc_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [obc_pkg::PIXEL_W-1:0]    m_pixel,
    output logic                           m_saturated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [obc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [obc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_BOX > 1) ? $clog2(MAX_BOX) : 1;
    localparam int CNT_W = $clog2(MAX_BOX + 1);

    obc_pkg::cmd_t    cmd;
    obc_pkg::sts_t    sts;
    logic [IDX_W-1:0] fill_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] box_n;

    obc_ctrl #(
        .MAX_BOX     (MAX_BOX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .fill_idx  (fill_idx),
        .rd_addr   (rd_addr),
        .box_n     (box_n)
    );

    obc_datapath #(
        .MAX_BOX     (MAX_BOX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .fill_idx    (fill_idx),
        .rd_addr     (rd_addr),
        .box_n       (box_n),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel     (m_pixel),
        .m_saturated (m_saturated)
    );

endmodule

[tb/sv/oversample_box_combiner_top_tb.sv]
`timescale 1ns / 1ps

module oversample_box_combiner_top_tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_sample = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_pixel;
    logic        m_saturated;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;

    oversample_box_combiner_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel(m_pixel),
        .m_saturated(m_saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    typedef struct packed {
        logic [15:0] pixel;
        logic        saturated;
    } pixel_word_t;

    typedef struct {
        logic [1:0]  mode;
        logic [4:0]  box;
        logic        sgn;
        logic [15:0] sample;
        logic        typed;
        logic [15:0] pixel;
        logic        saturated;
    } stim_row_t;

    pixel_word_t pixel_queue[$];
    int          errors = 0;
    int          pixels_seen = 0;
    int          samples_sent = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off = 0;
    logic        hold_req = 1'b0;
    logic        hold_used = 1'b0;

    // predictor state
    obc_pkg::mode_t cur_mode = obc_pkg::MODE_AVG;
    logic [4:0]    cur_box = 5'd1;
    logic          cur_sgn = 1'b0;
    int            fill = 0;
    longint        acc = 0;
    longint        run_max = 0;
    logic          clip = 1'b0;
    logic [15:0]   box_mem[16];

    function automatic longint as_value(logic [15:0] raw);
        if (cur_sgn && raw[15])
            return longint'(raw) - 65536;
        return longint'(raw);
    endfunction

    function automatic int box_len();
        if (cur_box == 0)
            return 1;
        if (cur_box > 16)
            return 16;
        return int'(cur_box);
    endfunction

    function automatic void clear_box();
        fill = 0;
        acc = 0;
        run_max = 0;
        clip = 1'b0;
    endfunction

    task automatic combine_sample(input logic [15:0] raw, input logic typed,
                                  input pixel_word_t typed_word);
        int          n;
        longint      s;
        longint      t;
        longint      hi;
        longint      lo;
        longint      pix;
        longint      sorted[16];
        longint      key;
        int          j;
        pixel_word_t w;
        n = box_len();
        s = as_value(raw);
        hi = cur_sgn ? 32767 : 65535;
        lo = cur_sgn ? -32768 : 0;
        if (fill >= n)
            clear_box();
        box_mem[fill] = raw;
        if (fill == 0) begin
            acc = s;
            run_max = s;
        end else begin
            t = acc + s;
            if (cur_mode == obc_pkg::MODE_SUM) begin
                if (t > hi) begin
                    t = hi;
                    clip = 1'b1;
                end else if (t < lo) begin
                    t = lo;
                    clip = 1'b1;
                end
            end
            acc = t;
            if (s > run_max)
                run_max = s;
        end
        fill++;
        if (fill < n)
            return;
        w.saturated = 1'b0;
        case (cur_mode)
            obc_pkg::MODE_AVG: pix = acc / n;
            obc_pkg::MODE_SUM: begin
                pix = acc;
                w.saturated = clip;
            end
            obc_pkg::MODE_MAX: pix = run_max;
            default: begin
                for (int i = 0; i < n; i++)
                    sorted[i] = as_value(box_mem[i]);
                for (int i = 1; i < n; i++) begin
                    key = sorted[i];
                    j = i;
                    while (j > 0 && sorted[j-1] > key) begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = key;
                end
                pix = sorted[n/2];
            end
        endcase
        w.pixel = pix[15:0];
        if (typed && w != typed_word) begin
            $display("%0t typed row disagrees: table %h/%b predictor %h/%b", $time,
                     typed_word.pixel, typed_word.saturated, w.pixel, w.saturated);
            errors++;
        end
        pixel_queue.push_back(w);
        clear_box();
    endtask

    task automatic write_reg(input obc_pkg::cfg_idx_t idx, input logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            obc_pkg::CFG_MODE:   cur_mode = obc_pkg::mode_t'(val[1:0]);
            obc_pkg::CFG_BOX:    cur_box = val;
            default:             cur_sgn = val[0];
        endcase
        clear_box();
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [1:0] md, input logic [4:0] bx, input logic sg);
        wait_idle();
        write_reg(obc_pkg::CFG_MODE, {3'b0, md});
        write_reg(obc_pkg::CFG_BOX, bx);
        write_reg(obc_pkg::CFG_SIGNED, {4'b0, sg});
    endtask

    task automatic send_sample(input logic [15:0] raw, input logic typed,
                               input pixel_word_t typed_word);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_sample <= raw;
        do @(posedge aclk); while (!s_ready);
        combine_sample(raw, typed, typed_word);
        samples_sent++;
    endtask

    // receiver
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            pixels_seen++;
            if (pixel_queue.size() == 0) begin
                $display("%0t unexpected pixel %h sat %b", $time, m_pixel, m_saturated);
                errors++;
            end else begin
                if (m_pixel !== pixel_queue[0].pixel ||
                    m_saturated !== pixel_queue[0].saturated) begin
                    $display("%0t mismatch: expected %h/%b actual %h/%b", $time,
                             pixel_queue[0].pixel, pixel_queue[0].saturated,
                             m_pixel, m_saturated);
                    errors++;
                end
                void'(pixel_queue.pop_front());
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_off <= 300;
            hold_used <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    stim_row_t rows[$];

    function automatic stim_row_t mk(logic [1:0] md, logic [4:0] bx, logic sg,
                                     logic [15:0] smp, logic ty, logic [15:0] px,
                                     logic st);
        stim_row_t r;
        r.mode = md; r.box = bx; r.sgn = sg; r.sample = smp;
        r.typed = ty; r.pixel = px; r.saturated = st;
        return r;
    endfunction

    logic [1:0]  r_mode;
    logic [4:0]  r_box;
    logic        r_sgn;
    int          n;
    logic [15:0] raw;

    initial begin
        // box of 1 after reset, extremes pass straight through
        rows.push_back(mk(0, 1, 0, 16'hffff, 1, 16'hffff, 0));
        rows.push_back(mk(0, 1, 0, 16'h0000, 1, 16'h0000, 0));
        rows.push_back(mk(0, 1, 1, 16'h8000, 1, 16'h8000, 0));
        // box factor of zero acts as one
        rows.push_back(mk(2, 0, 0, 16'h1234, 1, 16'h1234, 0));
        // saturating sum, unsigned high limit
        rows.push_back(mk(1, 2, 0, 16'hffff, 0, 0, 0));
        rows.push_back(mk(1, 2, 0, 16'hffff, 1, 16'hffff, 1));
        // signed sum clamps at the low limit
        rows.push_back(mk(1, 2, 1, 16'h8000, 0, 0, 0));
        rows.push_back(mk(1, 2, 1, 16'h8000, 1, 16'h8000, 1));
        // signed average truncates toward zero
        rows.push_back(mk(0, 2, 1, 16'hffff, 0, 0, 0));
        rows.push_back(mk(0, 2, 1, 16'hfffe, 0, 0, 0));
        // maximum, signed
        rows.push_back(mk(2, 3, 1, 16'h8000, 0, 0, 0));
        rows.push_back(mk(2, 3, 1, 16'hffff, 0, 0, 0));
        rows.push_back(mk(2, 3, 1, 16'h7fff, 0, 0, 0));
        // median of three, unsigned
        rows.push_back(mk(3, 3, 0, 16'h0009, 0, 0, 0));
        rows.push_back(mk(3, 3, 0, 16'h0001, 0, 0, 0));
        rows.push_back(mk(3, 3, 0, 16'h0005, 1, 16'h0005, 0));
        // box above the limit saturates to sixteen
        for (int i = 0; i < 16; i++)
            rows.push_back(mk(3, 31, 1, 16'(i * 4099), 0, 0, 0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].mode != cur_mode || rows[i].box != cur_box ||
                rows[i].sgn != cur_sgn)
                configure(rows[i].mode, rows[i].box, rows[i].sgn);
            send_sample(rows[i].sample, rows[i].typed,
                        '{pixel: rows[i].pixel, saturated: rows[i].saturated});
        end

        // mid-box write discards the partial box
        configure(0, 4, 0);
        send_sample(16'h0100, 0, '0);
        send_sample(16'h0200, 0, '0);
        wait_idle();
        write_reg(obc_pkg::CFG_MODE, 5'd1);
        for (int i = 0; i < 4; i++)
            send_sample(16'h4000, 0, '0);

        // block fills while the receiver holds off
        configure(2, 1, 0);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_sample(16'($urandom), 0, '0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 80 : 0;
            recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 17 : 0;
            for (int k = 0; k < 600;) begin
                r_mode = 2'($urandom_range(3));
                case ($urandom_range(5))
                    0: r_box = 5'd1;
                    1: r_box = 5'd16;
                    2: r_box = 5'($urandom_range(31));
                    default: r_box = 5'($urandom_range(2, 6));
                endcase
                r_sgn = 1'($urandom_range(1));
                configure(r_mode, r_box, r_sgn);
                n = 3 + $urandom_range(30);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(7))
                        0: raw = 16'hffff;
                        1: raw = 16'h8000;
                        2: raw = 16'h7fff;
                        3: raw = 16'h0000;
                        default: raw = 16'($urandom);
                    endcase
                    send_sample(raw, 0, '0);
                end
                k += n;
            end
        end

        wait_idle();
        $display("sent %0d samples, checked %0d pixels across all modes and box sizes",
                 samples_sent, pixels_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
